// ===== hw/rtl/ppid_pkg.sv =====
// ----------------------------------------------------------------------------
// ppid_pkg: shared types and constants of the positional PID block
// Widths, register indexes and the configuration and step structures.
// ----------------------------------------------------------------------------
package ppid_pkg;

   // Sample width of target and measured
   localparam int DATA_WIDTH = 16;

   // Fixed field widths
   localparam int GAIN_W   = 16;
   localparam int LIM_W    = 15;
   localparam int MINERR_W = 16;
   localparam int INT_W    = 16;
   localparam int DRIVE_W  = 16;
   localparam int FRAC_W   = 8;

   // Operation codes of the input transfer
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_I_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND  = 3'd5;

   // Derived datapath widths
   localparam int ERR_W   = DATA_WIDTH + 1;
   localparam int MAG_W   = (ERR_W > MINERR_W) ? ERR_W : MINERR_W;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int PROD_W  = GAIN_W + ERR_W;
   localparam int DPROD_W = GAIN_W + DIFF_W;
   localparam int PTERM_W = PROD_W - FRAC_W;
   localparam int DTERM_W = DPROD_W - FRAC_W;
   localparam int ISUM_W  = ((PTERM_W > INT_W) ? PTERM_W : INT_W) + 1;
   localparam int SUM_W   = DTERM_W + 2;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp_gain;
      logic signed [GAIN_W-1:0] ki_gain;
      logic signed [GAIN_W-1:0] kd_gain;
      logic [LIM_W-1:0]         i_limit;
      logic [LIM_W-1:0]         out_limit;
      logic [MINERR_W-1:0]      deadband;
   } ppid_cfg_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [ERR_W-1:0]   last_error;
      logic signed [INT_W-1:0]   integral;
   } ppid_step_type;

endpackage

// ===== hw/rtl/positional_pid_with_deadband.sv =====
// ----------------------------------------------------------------------------
// positional_pid_with_deadband: positional PID step with deadband and clamps
// Input register, single-pass control step and result register.
// ----------------------------------------------------------------------------
// A transfer on the req_ channel carries one sample pair (or a clear op when
// req_op is high) and produces exactly one drive value on the rsp_ channel.
// The block takes one transfer per clock cycle when rsp_ready is held high;
// an input transfer fills the input register, and the step result then
// moves into the result register, which drives rsp_valid. The stored
// integral and last error feed back through the step logic. Gains are
// signed
// Q8.8; each term is floor-shifted by 8, the integral is clamped to
// +/- i_limit and the drive to +/- out_limit. A clear op zeroes both the
// integral and the last error and returns a drive of 0. Write the csr_
// registers only while no transfer is in flight; valid flags, loop state and
// config reset to zero (payload registers do not); no clearing pass is needed.
module positional_pid_with_deadband (
   input  logic                                     clock,
   input  logic                                     reset,
   // input channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_op,
   input  logic signed [ppid_pkg::DATA_WIDTH-1:0]   req_target,
   input  logic signed [ppid_pkg::DATA_WIDTH-1:0]   req_measured,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [ppid_pkg::DRIVE_W-1:0]      rsp_drive,
   // configuration port
   input  logic                                     csr_wr_en,
   input  logic [ppid_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ppid_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int DATA_WIDTH = ppid_pkg::DATA_WIDTH;
   localparam int ERR_W      = ppid_pkg::ERR_W;
   localparam int INT_W      = ppid_pkg::INT_W;
   localparam int DRIVE_W    = ppid_pkg::DRIVE_W;

   ppid_pkg::ppid_cfg_type  cfg;
   ppid_pkg::ppid_step_type step;

   // input register
   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic                          in_op_ff;
   logic signed [DATA_WIDTH-1:0]  in_target_ff;
   logic signed [DATA_WIDTH-1:0]  in_measured_ff;

   // controller state
   logic signed [ERR_W-1:0]       last_error_ff;
   logic signed [INT_W-1:0]       integral_ff;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [DRIVE_W-1:0]     rsp_drive_ff;

   logic                          req_xfer;
   logic                          advance;

   // Advance the held item into the result register when that register is
   // empty or its value is being taken in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Take a new item whenever the input register is empty or moves on.
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   ppid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppid_calc u_calc (
      .cfg        (cfg),
      .op         (in_op_ff),
      .target     (in_target_ff),
      .measured   (in_measured_ff),
      .last_error (last_error_ff),
      .integral   (integral_ff),
      .step       (step)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // commit the loop state only when the step's result moves on
         if (advance) begin
            last_error_ff <= step.last_error;
            integral_ff   <= step.integral;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_op_ff       <= req_op;
         in_target_ff   <= req_target;
         in_measured_ff <= req_measured;
      end
      if (advance) begin
         rsp_drive_ff <= step.drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   logic signed [DRIVE_W-1:0] out_lim_s;
   assign out_lim_s = DRIVE_W'($signed({1'b0, cfg.out_limit}));

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      advance && in_op_ff |=> rsp_drive_ff == '0 && integral_ff == '0
                              && last_error_ff == '0)
      else $error("clear op left non-zero drive or state");

   a_drive_bounded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_drive_ff <= $past(out_lim_s) && rsp_drive_ff >= -$past(out_lim_s))
      else $error("drive outside the output limit");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(integral_ff) && $stable(last_error_ff))
      else $error("loop state changed without a step");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_target_ff)
                                  && $stable(in_measured_ff) && $stable(in_op_ff))
      else $error("stalled input item lost or changed");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_drive_ff))
      else $error("waiting result lost or overwritten");

endmodule

// ===== hw/rtl/ppid_csr.sv =====
// ----------------------------------------------------------------------------
// ppid_csr: configuration registers
// Decode the write port and hold gains, limits and deadband.
// ----------------------------------------------------------------------------
module ppid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ppid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppid_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ppid_pkg::ppid_cfg_type              cfg
);

   localparam int LIM_W = ppid_pkg::LIM_W;

   ppid_pkg::ppid_cfg_type cfg_ff;
   ppid_pkg::ppid_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ppid_pkg::CSR_KP_GAIN:   cfg_in.kp_gain   = $signed(csr_wdata);
            ppid_pkg::CSR_KI_GAIN:   cfg_in.ki_gain   = $signed(csr_wdata);
            ppid_pkg::CSR_KD_GAIN:   cfg_in.kd_gain   = $signed(csr_wdata);
            ppid_pkg::CSR_I_LIMIT:   cfg_in.i_limit   = csr_wdata[LIM_W-1:0];
            ppid_pkg::CSR_OUT_LIMIT: cfg_in.out_limit = csr_wdata[LIM_W-1:0];
            ppid_pkg::CSR_DEADBAND:  cfg_in.deadband  = csr_wdata;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/ppid_calc.sv =====
// ----------------------------------------------------------------------------
// ppid_calc: single control step
// Error with deadband, three Q8.8 products, integral and output clamps; a clear op yields an all-zero step.
// ----------------------------------------------------------------------------
module ppid_calc (
   input  ppid_pkg::ppid_cfg_type                       cfg,
   input  logic                                         op,
   input  logic signed [ppid_pkg::DATA_WIDTH-1:0]       target,
   input  logic signed [ppid_pkg::DATA_WIDTH-1:0]       measured,
   input  logic signed [ppid_pkg::ERR_W-1:0]            last_error,
   input  logic signed [ppid_pkg::INT_W-1:0]            integral,
   output ppid_pkg::ppid_step_type                      step
);

   localparam int ERR_W   = ppid_pkg::ERR_W;
   localparam int MAG_W   = ppid_pkg::MAG_W;
   localparam int DIFF_W  = ppid_pkg::DIFF_W;
   localparam int PROD_W  = ppid_pkg::PROD_W;
   localparam int DPROD_W = ppid_pkg::DPROD_W;
   localparam int PTERM_W = ppid_pkg::PTERM_W;
   localparam int DTERM_W = ppid_pkg::DTERM_W;
   localparam int ISUM_W  = ppid_pkg::ISUM_W;
   localparam int SUM_W   = ppid_pkg::SUM_W;
   localparam int INT_W   = ppid_pkg::INT_W;
   localparam int DRIVE_W = ppid_pkg::DRIVE_W;
   localparam int FRAC_W  = ppid_pkg::FRAC_W;

   logic signed [ERR_W-1:0]   err_raw;
   logic signed [ERR_W-1:0]   err_neg;
   logic [MAG_W-1:0]          err_mag;
   logic signed [ERR_W-1:0]   err_db;
   logic signed [PROD_W-1:0]  kp_prod;
   logic signed [PROD_W-1:0]  ki_prod;
   logic signed [DIFF_W-1:0]  err_diff;
   logic signed [DPROD_W-1:0] kd_prod;
   logic signed [PTERM_W-1:0] p_term;
   logic signed [PTERM_W-1:0] i_term;
   logic signed [DTERM_W-1:0] d_term;
   logic signed [ISUM_W-1:0]  isum;
   logic signed [ISUM_W-1:0]  ilim;
   logic signed [ISUM_W-1:0]  iclamp;
   logic signed [INT_W-1:0]   integral_new;
   logic signed [SUM_W-1:0]   osum;
   logic signed [SUM_W-1:0]   olim;
   logic signed [SUM_W-1:0]   oclamp;

   always_comb begin
      // error and deadband; a magnitude equal to the deadband passes
      err_raw = ERR_W'(target) - ERR_W'(measured);
      err_neg = -err_raw;
      err_mag = MAG_W'($unsigned(err_raw[ERR_W-1] ? err_neg : err_raw));
      err_db  = (err_mag < MAG_W'(cfg.deadband)) ? '0 : err_raw;

      // products, floor-shifted back to integer scale
      kp_prod  = PROD_W'(cfg.kp_gain) * PROD_W'(err_db);
      ki_prod  = PROD_W'(cfg.ki_gain) * PROD_W'(err_db);
      err_diff = DIFF_W'(err_db) - DIFF_W'(last_error);
      kd_prod  = DPROD_W'(cfg.kd_gain) * DPROD_W'(err_diff);
      p_term   = PTERM_W'(kp_prod >>> FRAC_W);
      i_term   = PTERM_W'(ki_prod >>> FRAC_W);
      d_term   = DTERM_W'(kd_prod >>> FRAC_W);

      // integral with anti-windup clamp
      isum = ISUM_W'(integral) + ISUM_W'(i_term);
      ilim = ISUM_W'($signed({1'b0, cfg.i_limit}));
      if (isum > ilim) begin
         iclamp = ilim;
      end else if (isum < -ilim) begin
         iclamp = -ilim;
      end else begin
         iclamp = isum;
      end
      integral_new = INT_W'(iclamp);

      // output sum and clamp
      osum = SUM_W'(p_term) + SUM_W'(integral_new) + SUM_W'(d_term);
      olim = SUM_W'($signed({1'b0, cfg.out_limit}));
      if (osum > olim) begin
         oclamp = olim;
      end else if (osum < -olim) begin
         oclamp = -olim;
      end else begin
         oclamp = osum;
      end

      if (op == ppid_pkg::OP_CLEAR) begin
         step = '0;
      end else begin
         step.drive      = DRIVE_W'(oclamp);
         step.last_error = err_db;
         step.integral   = integral_new;
      end
   end

endmodule
